// ===== sv/load_cell_window_average_weigh_unit_assert.svh =====
// Assertion macros for the load-cell window averager and weigher.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LOAD_CELL_WINDOW_AVERAGE_WEIGH_UNIT_ASSERT_SVH
`define LOAD_CELL_WINDOW_AVERAGE_WEIGH_UNIT_ASSERT_SVH

// Same-cycle implication
`define LCW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LCW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lcw_pkg.sv =====
// Shared constants and types for the load-cell window averager and weigher.
// No dependencies; imported by every module of the block but the port checker.
`timescale 1ns / 1ps

package lcw_pkg;

  localparam int RING_DEPTH = 255;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = 32;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int WEIGHT_W = 32;

  // Shared divider: for the weight divide the dividend holds |diff| * 2^32, divisor |counts_per_unit|
  localparam int DIV_DW = DIFF_W + 32;
  localparam int DIV_VW = 32;
  localparam int DIV_CW = $clog2(DIV_DW + 1);

  // Unit conversion
  localparam int KW     = 18;
  localparam int QC_W   = 41;
  localparam int MUL_AW = 24;
  localparam int PROD_W = MUL_AW + KW;
  localparam int ACC_W  = QC_W + KW;

  localparam logic [KW-1:0] KG_TO_LB_Q16 = KW'(144482);
  localparam logic [KW-1:0] LB_TO_KG_Q16 = KW'(29727);

  typedef enum logic [2:0] {
    CFG_WINDOW_LENGTH    = 3'd0,
    CFG_TARE_OFFSET      = 3'd1,
    CFG_COUNTS_PER_UNIT  = 3'd2,
    CFG_DISPLAY_UNIT     = 3'd3,
    CFG_CALIBRATION_UNIT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/lcw_ring.sv =====
// Sample ring store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
`timescale 1ns / 1ps

module lcw_ring import lcw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [RING_AW-1:0]         wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic [RING_AW-1:0]         rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [RING_DEPTH-1:0]      vld_r;
  logic signed [SAMPLE_W-1:0] rd_mem_r;
  logic                       rd_vld_r;
  logic                       wr_ok;
  logic                       rd_ok;

  assign wr_ok = wr_en && (int'(wr_addr) < RING_DEPTH);
  assign rd_ok = int'(rd_addr) < RING_DEPTH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= rd_ok ? vld_r[rd_addr] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_ok) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_mem_r : '0;

endmodule

// ===== sv/lcw_div.sv =====
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Runs a given number of steps; the quotient sits in the low bits afterwards.
`timescale 1ns / 1ps

module lcw_div import lcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  input  logic [DIV_CW-1:0] steps,
  output div_stat_t         stat,
  output logic [DIV_DW-1:0] quotient
);

  logic [DIV_VW-1:0] rem_r;
  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_VW:0]   rem_sh;
  logic              ge;
  logic [DIV_VW-1:0] rem_nxt;
  logic [DIV_DW-1:0] quo_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_DW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? DIV_VW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIV_VW-1:0];
    quo_nxt = {quo_r[DIV_DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      quo_r  <= '0;
      dvs_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
        cnt_r  <= steps;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== sv/load_cell_window_average_weigh_unit.sv =====
// An accepted sample passes the window sum, the average divide in the shared divider, the
// divide by counts_per_unit, the multiply (S_MUL0, S_MUL1) when the units differ and the output
// register; a zero window skips the average divide, a zero factor the divide and multiply.
// in_ready is high in idle only, so a new item waits until the last result has been loaded.
// Reset (rst_n low, synchronous) restores register defaults, clears the ring
// valid bits, the write index, the held average and the output channel.
`timescale 1ns / 1ps

module load_cell_window_average_weigh_unit import lcw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_average_raw,
  output logic signed [WEIGHT_W-1:0] out_weight,
  output logic                       out_divide_error
);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_DIV1, S_AVG, S_DIV2, S_MUL0, S_MUL1, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [7:0]                 win_cfg_r;
  logic signed [SAMPLE_W-1:0] tare_r;
  logic signed [31:0]         cpu_r;
  logic                       disp_r;
  logic                       cal_r;

  // datapath
  logic [RING_AW-1:0]         win_r;
  logic [RING_AW-1:0]         wi_r;
  logic [RING_AW-1:0]         cnt_r;
  logic                       pend_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] held_r;
  logic                       qs_r;
  logic [DIV_DW-1:0]          mag_r;
  logic [ACC_W-1:0]           acc_r;
  logic                       err_r;

  logic                       div_start_r;
  logic [DIV_DW-1:0]          div_dvd_r;
  logic [DIV_VW-1:0]          div_dvs_r;
  logic [DIV_CW-1:0]          div_steps_r;
  div_stat_t                  div_stat;
  logic [DIV_DW-1:0]          div_quo;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_avg_r;
  logic signed [WEIGHT_W-1:0] out_weight_r;
  logic                       out_err_r;

  logic                       in_acc;
  logic [RING_AW-1:0]         win_now;
  logic [RING_AW-1:0]         wi_inc;
  logic [RING_AW-1:0]         wi_nxt;
  logic                       issue;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [SUM_W-1:0]           sum_mag;
  logic [SAMPLE_W-1:0]        avg_mag;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          diff_mag;
  logic [DIV_VW-1:0]          cpu_mag;
  logic [QC_W-1:0]            qc;
  logic [KW-1:0]              k;
  logic [MUL_AW-1:0]          mul_a;
  logic [PROD_W-1:0]          prod;
  logic [ACC_W-1:0]           acc_nxt;
  logic signed [WEIGHT_W-1:0] sat_weight;
  logic                       out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    win_now = (int'(win_cfg_r) > RING_DEPTH) ? RING_AW'(RING_DEPTH) : RING_AW'(win_cfg_r);
    wi_inc  = wi_r + 1'b1;
    wi_nxt  = (wi_inc >= win_now) ? '0 : wi_inc;
    issue   = cnt_r < win_r;
    sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    avg_mag = div_quo[SAMPLE_W-1:0];
    diff     = DIFF_W'(held_r) - DIFF_W'(tare_r);
    diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    cpu_mag  = cpu_r[31] ? DIV_VW'(-cpu_r) : DIV_VW'(cpu_r);
    // clamp the quotient magnitude to 2^40 before conversion
    qc    = (mag_r > DIV_DW'(64'd1 << 40)) ? QC_W'(64'd1 << 40) : mag_r[QC_W-1:0];
    k     = cal_r ? LB_TO_KG_Q16 : KG_TO_LB_Q16;
    mul_a = (state_r == S_MUL1) ? MUL_AW'(qc[QC_W-1:MUL_AW]) : qc[MUL_AW-1:0];
    prod  = mul_a * k;
    acc_nxt = acc_r + {prod[QC_W-MUL_AW+KW-1:0], {MUL_AW{1'b0}}};
    if (qs_r) begin
      sat_weight = (mag_r > DIV_DW'(64'h8000_0000)) ? WEIGHT_W'(32'h8000_0000)
                                                    : WEIGHT_W'(-mag_r[WEIGHT_W-1:0]);
    end else begin
      sat_weight = (mag_r > DIV_DW'(64'h7FFF_FFFF)) ? WEIGHT_W'(32'h7FFF_FFFF)
                                                    : WEIGHT_W'(mag_r[WEIGHT_W-1:0]);
    end
    out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  lcw_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_addr (wi_r),
    .wr_data (in_sample),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  lcw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .steps    (div_steps_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= 8'd16;
      tare_r    <= '0;
      cpu_r     <= 32'sd65536;
      disp_r    <= 1'b0;
      cal_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:    win_cfg_r <= cfg_data[7:0];
        CFG_TARE_OFFSET:      tare_r    <= cfg_data[SAMPLE_W-1:0];
        CFG_COUNTS_PER_UNIT:  cpu_r     <= cfg_data;
        CFG_DISPLAY_UNIT:     disp_r    <= cfg_data[0];
        CFG_CALIBRATION_UNIT: cal_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_r        <= '0;
      wi_r         <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      sum_r        <= '0;
      held_r       <= '0;
      qs_r         <= 1'b0;
      mag_r        <= '0;
      acc_r        <= '0;
      err_r        <= 1'b0;
      div_start_r  <= 1'b0;
      div_dvd_r    <= '0;
      div_dvs_r    <= '0;
      div_steps_r  <= '0;
      out_valid_r  <= 1'b0;
      out_avg_r    <= '0;
      out_weight_r <= '0;
      out_err_r    <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            win_r   <= win_now;
            wi_r    <= wi_nxt;
            cnt_r   <= '0;
            pend_r  <= 1'b0;
            sum_r   <= '0;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          // read address leads the accumulate, which adds the ring data in the next cycle
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
          end
          pend_r <= issue;
          if (pend_r) begin
            sum_r <= sum_r + SUM_W'(rd_data);
          end
          if (!issue && !pend_r) begin
            if (win_r == '0) begin
              state_r <= S_AVG;
            end else begin
              div_start_r <= 1'b1;
              div_dvd_r   <= {sum_mag, {(DIV_DW-SUM_W){1'b0}}};
              div_dvs_r   <= DIV_VW'(win_r);
              div_steps_r <= DIV_CW'(SUM_W);
              state_r     <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_stat.done) begin
            held_r  <= sum_r[SUM_W-1] ? SAMPLE_W'(-avg_mag) : SAMPLE_W'(avg_mag);
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          if (cpu_r == '0) begin
            err_r   <= 1'b1;
            qs_r    <= 1'b0;
            mag_r   <= '0;
            state_r <= S_DONE;
          end else begin
            err_r       <= 1'b0;
            qs_r        <= diff[DIFF_W-1] ^ cpu_r[31];
            div_start_r <= 1'b1;
            div_dvd_r   <= {diff_mag, {(DIV_DW-DIFF_W){1'b0}}};
            div_dvs_r   <= cpu_mag;
            div_steps_r <= DIV_CW'(DIV_DW);
            state_r     <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_stat.done) begin
            mag_r   <= div_quo;
            state_r <= (disp_r != cal_r) ? S_MUL0 : S_DONE;
          end
        end
        S_MUL0: begin
          acc_r   <= ACC_W'(prod);
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          // drop the 16 fraction bits of the Q2.16 factor
          mag_r   <= DIV_DW'(acc_nxt >> 16);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_avg_r    <= held_r;
            out_weight_r <= sat_weight;
            out_err_r    <= err_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average_raw  = out_avg_r;
  assign out_weight       = out_weight_r;
  assign out_divide_error = out_err_r;

endmodule

// ===== sv/lcw_checker.sv =====
// Port-level checks for the load-cell window averager and weigher.
// Uses the assertion macros header; bound to the top level below.
`timescale 1ns / 1ps
`include "load_cell_window_average_weigh_unit_assert.svh"

module lcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_average_raw,
  input logic [31:0] out_weight,
  input logic        out_divide_error
);

  `LCW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_weight) && $stable(out_average_raw) && $stable(out_divide_error), "result item changed while stalled")

  `LCW_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after an item was taken")

  `LCW_ASSERT_NXT(a_no_early_result, in_valid && in_ready, $stable(out_weight) && $stable(out_average_raw), "result changed right after an item was taken")

  `LCW_ASSERT_IMP(a_err_weight_zero, out_valid && out_divide_error, out_weight == 32'd0, "weight not zero on divide error")

endmodule

bind load_cell_window_average_weigh_unit lcw_checker u_lcw_checker (.*);

// ===== test/weigh_reading_checker.sv =====
`timescale 1ns / 1ps
// Reading checker for the load-cell window averager and weigher: follows register
// writes, predicts one reading per accepted sample and compares it with the output.
// Depends on lcw_pkg for field widths, ring depth and register indexes.

module weigh_reading_checker import lcw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_average_raw,
  input  logic signed [WEIGHT_W-1:0] out_weight,
  input  logic                       out_divide_error,
  output int                         mismatches,
  output int                         outstanding
);

  localparam longint KG_TO_LB   = 144482;
  localparam longint LB_TO_KG   = 29727;
  localparam longint Q_LIMIT    = longint'(1) <<< 40;
  localparam longint WEIGHT_MAX = 64'sd2147483647;
  localparam longint WEIGHT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       err;
  } reading_t;

  reading_t expected_readings[$];

  logic signed [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
  logic [7:0]                 wr_idx;
  logic signed [SAMPLE_W-1:0] avg_hold;

  logic [7:0]                 win_len;
  logic signed [SAMPLE_W-1:0] tare;
  logic signed [31:0]         cpu;
  logic                       disp_unit;
  logic                       cal_unit;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic reading_t weigh_sample(logic signed [SAMPLE_W-1:0] s);
    int unsigned win;
    longint      sum;
    longint      diff;
    longint      q;
    reading_t    r;
    win = (win_len > RING_DEPTH) ? RING_DEPTH : win_len;
    if (wr_idx < RING_DEPTH) ring_copy[wr_idx] = s;
    wr_idx = wr_idx + 8'd1;
    if (wr_idx >= win) wr_idx = '0;
    sum = 0;
    for (int i = 0; i < win; i++) sum += ring_copy[i];
    // a zero window keeps the previous average
    if (win != 0) avg_hold = SAMPLE_W'(sum / longint'(win));
    r.avg    = avg_hold;
    r.err    = 1'b0;
    r.weight = '0;
    if (cpu == 0) begin
      r.err = 1'b1;
    end else begin
      diff = longint'(avg_hold) - longint'(tare);
      q    = (diff * (longint'(1) <<< 32)) / longint'(cpu);
      if (disp_unit != cal_unit) begin
        if (q > Q_LIMIT) q = Q_LIMIT;
        else if (q < -Q_LIMIT) q = -Q_LIMIT;
        q = (q * (cal_unit ? LB_TO_KG : KG_TO_LB)) / longint'(65536);
      end
      if (q > WEIGHT_MAX) q = WEIGHT_MAX;
      else if (q < WEIGHT_MIN) q = WEIGHT_MIN;
      r.weight = WEIGHT_W'(q);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      foreach (ring_copy[i]) ring_copy[i] = '0;
      wr_idx    = '0;
      avg_hold  = '0;
      win_len   = 8'd16;
      tare      = '0;
      cpu       = 32'sd65536;
      disp_unit = 1'b0;
      cal_unit  = 1'b0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH:    win_len   = cfg_data[7:0];
          CFG_TARE_OFFSET:      tare      = cfg_data[SAMPLE_W-1:0];
          CFG_COUNTS_PER_UNIT:  cpu       = cfg_data;
          CFG_DISPLAY_UNIT:     disp_unit = cfg_data[0];
          CFG_CALIBRATION_UNIT: cal_unit  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_readings.push_back(weigh_sample(in_sample));
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading: expected none, actual avg %0d weight %0d err %0b",
                   $time, out_average_raw, out_weight, out_divide_error);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (out_average_raw !== want.avg) begin
            $display("%0t: average_raw expected %0d actual %0d",
                     $time, want.avg, out_average_raw);
            mismatches++;
          end
          if (out_weight !== want.weight) begin
            $display("%0t: weight expected %0d actual %0d", $time, want.weight, out_weight);
            mismatches++;
          end
          if (out_divide_error !== want.err) begin
            $display("%0t: divide_error expected %0b actual %0b",
                     $time, want.err, out_divide_error);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_readings.size();
  end

endmodule

// ===== test/tb_load_cell_window_average_weigh_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the load-cell window averager and weigher: drives register writes and
// samples, the samples with random gaps, and gives the verdict.
// Depends on lcw_pkg, the block itself and weigh_reading_checker.

module tb_load_cell_window_average_weigh_unit;
  import lcw_pkg::*;

  localparam int NUM_REGS       = 5;
  localparam int ITEM_TARGET    = 1150;
  localparam int MAX_GAP        = 18;
  localparam int DRAIN_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SAMPLE_MAX     = (1 <<< (SAMPLE_W - 1)) - 1;
  localparam int SAMPLE_MIN     = -(1 <<< (SAMPLE_W - 1));

  logic                       clk;
  logic                       rst_n            = 1'b0;
  logic                       cfg_valid        = 1'b0;
  logic                       cfg_ready;
  logic [2:0]                 cfg_index        = '0;
  logic [31:0]                cfg_data         = '0;
  logic                       in_valid         = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample        = '0;
  logic                       out_valid;
  logic                       out_ready        = 1'b0;
  logic signed [SAMPLE_W-1:0] out_average_raw;
  logic signed [WEIGHT_W-1:0] out_weight;
  logic                       out_divide_error;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int cur_tare    = 0;
  bit no_idle     = 1'b0;

  load_cell_window_average_weigh_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average_raw  (out_average_raw),
    .out_weight       (out_weight),
    .out_divide_error (out_divide_error)
  );

  weigh_reading_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average_raw  (out_average_raw),
    .out_weight       (out_weight),
    .out_divide_error (out_divide_error),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // reset the count on any accepted item, give up after a long silence
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stall a random number of cycles before taking each item
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold valid across back-to-back items, drop it only for a real gap
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // drop valid and wait until every reading has come back
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = SAMPLE_MAX;
      1: v = SAMPLE_MIN;
      2, 3, 4: begin
        v = cur_tare + int'($urandom_range(0, 8000)) - 4000;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      end
      default: v = $urandom;
    endcase
    return SAMPLE_W'(v);
  endfunction

  // rewrite a random subset of the registers, junk in the unused upper bits
  task automatic shuffle_settings();
    logic [31:0] junk;
    logic [31:0] cpu;
    logic [7:0]  win;
    int          t;
    junk = $urandom;
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0:          win = 8'd0;
        1:          win = 8'd1;
        2:          win = 8'd255;
        3, 4, 5:    win = 8'($urandom_range(2, 24));
        default:    win = 8'($urandom_range(0, 255));
      endcase
      write_reg(CFG_WINDOW_LENGTH, {junk[31:8], win});
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0:       t = SAMPLE_MIN;
        1:       t = SAMPLE_MAX;
        2:       t = 0;
        3, 4:    t = int'($urandom_range(0, 4000)) - 2000;
        default: t = int'(SAMPLE_W'($urandom)) - ($urandom_range(0, 1) ? 0 : 0);
      endcase
      if (t > SAMPLE_MAX) t = t - (1 <<< SAMPLE_W);
      cur_tare = t;
      write_reg(CFG_TARE_OFFSET, {junk[31:SAMPLE_W], SAMPLE_W'(t)});
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0:          cpu = 32'h0000_0000;
        1:          cpu = 32'h8000_0000;
        2:          cpu = 32'h7fff_ffff;
        3:          cpu = $urandom_range(0, 1) ? 32'h0000_0001 : 32'hffff_ffff;
        4, 5, 6: begin
          cpu = $urandom_range(256, 1 << 22);
          if ($urandom_range(0, 1)) cpu = -cpu;
        end
        default:    cpu = $urandom;
      endcase
      write_reg(CFG_COUNTS_PER_UNIT, cpu);
    end
    if ($urandom_range(0, 1)) write_reg(CFG_DISPLAY_UNIT, {junk[31:1], 1'($urandom_range(0, 1))});
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_CALIBRATION_UNIT, {junk[30:0], 1'($urandom_range(0, 1))});
    end
    if ($urandom_range(0, 5) == 0) write_reg(3'(NUM_REGS + $urandom_range(0, 2)), $urandom);
  endtask

  initial begin
    int random_sent;
    int burst;
    random_sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // register defaults: field extremes through a 16-entry window
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(SAMPLE_W'(SAMPLE_MIN));
    push_sample('0);
    push_sample(-1);
    push_sample(1);

    // single-entry window, tare at its top, unit factor: saturate low
    settle();
    write_reg(CFG_WINDOW_LENGTH, 32'd1);
    write_reg(CFG_TARE_OFFSET, 32'(SAMPLE_MAX));
    write_reg(CFG_COUNTS_PER_UNIT, 32'd1);
    push_sample(SAMPLE_W'(SAMPLE_MIN));
    push_sample(SAMPLE_W'(SAMPLE_MAX));

    // most negative factor, tare at its bottom, kilograms shown as pounds
    settle();
    write_reg(CFG_TARE_OFFSET, 32'hff80_0000);
    write_reg(CFG_COUNTS_PER_UNIT, 32'h8000_0000);
    write_reg(CFG_DISPLAY_UNIT, 32'd1);
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(SAMPLE_W'(SAMPLE_MIN));

    // zero factor across the full ring
    settle();
    write_reg(CFG_WINDOW_LENGTH, 32'd255);
    write_reg(CFG_COUNTS_PER_UNIT, 32'd0);
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(SAMPLE_W'(SAMPLE_MIN));

    // zero window holds the average; unknown register must change nothing
    settle();
    write_reg(3'(NUM_REGS), 32'hffff_ffff);
    write_reg(CFG_WINDOW_LENGTH, 32'hffff_ff00);
    write_reg(CFG_TARE_OFFSET, 32'd0);
    write_reg(CFG_COUNTS_PER_UNIT, 32'h7fff_ffff);
    write_reg(CFG_DISPLAY_UNIT, 32'd0);
    write_reg(CFG_CALIBRATION_UNIT, 32'd1);
    repeat (3) push_sample(SAMPLE_W'($urandom));

    // both units pounds, factor of minus one
    settle();
    write_reg(CFG_WINDOW_LENGTH, 32'd3);
    write_reg(CFG_TARE_OFFSET, 32'hffff_ffff);
    write_reg(CFG_COUNTS_PER_UNIT, 32'hffff_ffff);
    write_reg(CFG_DISPLAY_UNIT, 32'd1);
    repeat (4) push_sample(SAMPLE_W'(int'($urandom_range(0, 200)) - 100));

    // kilograms to pounds pushing past the top of the weight range
    settle();
    write_reg(CFG_WINDOW_LENGTH, 32'd2);
    write_reg(CFG_TARE_OFFSET, 32'd0);
    write_reg(CFG_COUNTS_PER_UNIT, 32'd65536);
    write_reg(CFG_CALIBRATION_UNIT, 32'd0);
    repeat (2) push_sample(SAMPLE_W'(SAMPLE_MAX));
    cur_tare = 0;

    while (random_sent < ITEM_TARGET) begin
      settle();
      shuffle_settings();
      no_idle = ($urandom_range(0, 3) == 0);
      burst   = $urandom_range(8, 60);
      repeat (burst) begin
        push_sample(pick_sample());
        random_sent++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
